// ===== sv/gradient_magnitude_filter_core_macros.svh =====
`ifndef GRADIENT_MAGNITUDE_FILTER_CORE_MACROS_SVH
`define GRADIENT_MAGNITUDE_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define GMF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmf assertion failed");

// Next-cycle implication, disabled in reset.
`define GMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmf assertion failed");

`endif

// ===== sv/gmf_pkg.sv =====
package gmf_pkg;

    localparam int MAX_SIZE       = 1024;
    localparam int ADDR_W         = $clog2(MAX_SIZE);
    localparam int CFG_W          = 11;
    localparam int PIX_W          = 16;
    localparam int COORD_W        = 10;
    localparam int IMAGE_SIZE_RST = 256;
    localparam int MIN_SIZE       = 2;

    localparam int GRAD_SCALE     = 100;
    localparam int SCALE_W        = 7;

    localparam int SQ_W           = 2 * PIX_W;
    localparam int SUM_W          = SQ_W + 1;
    localparam int ROOT_W         = (SUM_W + 1) / 2;
    localparam int VAL_W          = 2 * ROOT_W;
    localparam int REM_W          = ROOT_W + 3;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } gmf_coord_t;

endpackage

// ===== sv/gmf_ram.sv =====
module gmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/gmf_isqrt.sv =====
module gmf_isqrt
    import gmf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [SUM_W-1:0]  in_value,
    input  gmf_coord_t        in_tag,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ROOT_W-1:0] out_root,
    output gmf_coord_t        out_tag
);

    logic [ROOT_W-1:0] v_reg;
    logic [ROOT_W:0]   rdy;
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [VAL_W-1:0]  val_reg  [ROOT_W];
    gmf_coord_t        tag_reg  [ROOT_W];

    assign rdy[ROOT_W] = !out_stall;
    assign in_stall    = !rdy[0];

    // one result bit per stage
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        logic              prev_v;
        logic [REM_W-1:0]  rem_i;
        logic [ROOT_W-1:0] root_i;
        logic [VAL_W-1:0]  val_i;
        gmf_coord_t        tag_i;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign prev_v = in_valid;
            assign rem_i  = '0;
            assign root_i = '0;
            assign val_i  = {{(VAL_W-SUM_W){1'b0}}, in_value};
            assign tag_i  = in_tag;
        end
        else
        begin : g_rest
            assign prev_v = v_reg[i-1];
            assign rem_i  = rem_reg[i-1];
            assign root_i = root_reg[i-1];
            assign val_i  = val_reg[i-1];
            assign tag_i  = tag_reg[i-1];
        end

        assign rdy[i]  = !v_reg[i] || rdy[i+1];
        assign rem_sh  = {rem_i[REM_W-3:0], val_i[VAL_W-1:VAL_W-2]};
        assign trial   = {1'b0, root_i, 2'b01};
        assign ge      = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (rdy[i])
            begin
                v_reg[i] <= prev_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i] && prev_v)
            begin
                rem_reg[i]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[i] <= {root_i[ROOT_W-2:0], ge};
                val_reg[i]  <= {val_i[VAL_W-3:0], 2'b00};
                tag_reg[i]  <= tag_i;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];

endmodule

// ===== sv/gradient_magnitude_filter_core.sv =====
// Gradient magnitude filter for a square 16-bit height image in raster order.
// Input channel: pixel with in_valid/in_stall; a request is taken when
// in_valid is high and in_stall is low. Output channel: gradient, out_x,
// out_y with out_valid/out_stall, same rule.
// The pixel at (x,y) with x >= 1 and y >= 1 releases the result for
// (x-1,y-1); pixels in row 0 or column 0 release nothing.
// Throughput: one pixel per clock while the output is not stalled. The row
// store is read at the edge that accepts the releasing request; then the
// difference, square, sum, 17 root stages and scale are each registered in
// order before out_valid rises. The row store is one RAM read and written
// at the same column in the cycle of the request.
// cfg_we/cfg_data write image_size (saturated to 2..1024) and restart the
// image at (0,0); write it only while no request is in flight.
// Reset: empty pipeline, position (0,0), image_size 256. The row store is
// not cleared; row 0 fills it before it is read.
// A stalled output holds its result; the pipeline keeps taking pixels until
// its stages fill, then raises in_stall.
`include "gradient_magnitude_filter_core_macros.svh"

module gradient_magnitude_filter_core
    import gmf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PIX_W-1:0]   pixel,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [PIX_W-1:0]   gradient,
    output logic [COORD_W-1:0] out_x,
    output logic [COORD_W-1:0] out_y
);

    logic [ADDR_W-1:0] lim_reg, lim_next;
    logic [ADDR_W-1:0] x_reg, x_next;
    logic [ADDR_W-1:0] y_reg, y_next;
    logic              accept;
    logic              interior;
    int                cfg_size;

    logic [PIX_W-1:0]  above;
    logic              s1_v_reg, s1_res_reg, s1_go;
    logic [PIX_W-1:0]  s1_pix_reg;
    gmf_coord_t        s1_coord_reg;
    logic [PIX_W-1:0]  up_left_reg, left_reg;

    logic              s2_v_reg;
    logic [PIX_W-1:0]  adx_reg, ady_reg;
    gmf_coord_t        s2_coord_reg;

    logic              s3_v_reg;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg;
    gmf_coord_t        s3_coord_reg;

    logic              s4_v_reg;
    logic [SUM_W-1:0]  sum_reg;
    gmf_coord_t        s4_coord_reg;

    logic              rdy1, rdy2, rdy3, rdy4, rdyo;
    logic              sq_in_stall, sq_valid;
    logic [ROOT_W-1:0] sq_root;
    gmf_coord_t        sq_tag;
    logic [ROOT_W+SCALE_W-1:0] scaled;

    logic              out_v_reg;
    logic [PIX_W-1:0]  grad_reg;
    gmf_coord_t        out_coord_reg;

    assign accept   = in_valid && !in_stall;
    assign interior = (x_reg != '0) && (y_reg != '0);

    // size saturation and position
    always_comb
    begin
        cfg_size = int'(cfg_data);
        if (cfg_size < MIN_SIZE)
        begin
            cfg_size = MIN_SIZE;
        end
        if (cfg_size > MAX_SIZE)
        begin
            cfg_size = MAX_SIZE;
        end
        lim_next = lim_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        if (cfg_we)
        begin
            lim_next = ADDR_W'(cfg_size - 1);
            x_next   = '0;
            y_next   = '0;
        end
        else if (accept)
        begin
            if (x_reg == lim_reg)
            begin
                x_next = '0;
                y_next = (y_reg == lim_reg) ? '0 : y_reg + ADDR_W'(1);
            end
            else
            begin
                x_next = x_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= ADDR_W'(IMAGE_SIZE_RST - 1);
            x_reg   <= '0;
            y_reg   <= '0;
        end
        else
        begin
            lim_reg <= lim_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
        end
    end

    gmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_SIZE)
    ) u_row_store (
        .clk   (clk),
        .we    (accept),
        .waddr (x_reg),
        .wdata (pixel),
        .re    (accept),
        .raddr (x_reg),
        .rdata (above)
    );

    // handshake chain
    assign rdyo     = !out_v_reg || !out_stall;
    assign rdy4     = !s4_v_reg || !sq_in_stall;
    assign rdy3     = !s3_v_reg || rdy4;
    assign rdy2     = !s2_v_reg || rdy3;
    assign s1_go    = s1_v_reg && (!s1_res_reg || rdy2);
    assign rdy1     = !s1_v_reg || s1_go;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            s1_res_reg <= 1'b0;
            s2_v_reg   <= 1'b0;
            s3_v_reg   <= 1'b0;
            s4_v_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_v_reg   <= 1'b1;
                s1_res_reg <= interior;
            end
            else if (s1_go)
            begin
                s1_v_reg <= 1'b0;
            end
            if (rdy2)
            begin
                s2_v_reg <= s1_v_reg && s1_res_reg;
            end
            if (rdy3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (rdy4)
            begin
                s4_v_reg <= s3_v_reg;
            end
            if (rdyo)
            begin
                out_v_reg <= sq_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg     <= pixel;
            s1_coord_reg.x <= COORD_W'(x_reg - ADDR_W'(1));
            s1_coord_reg.y <= COORD_W'(y_reg - ADDR_W'(1));
        end
        if (s1_go)
        begin
            up_left_reg <= above;
            left_reg    <= s1_pix_reg;
        end
        if (rdy2 && s1_v_reg && s1_res_reg)
        begin
            adx_reg      <= (above >= up_left_reg) ? above - up_left_reg
                                                   : up_left_reg - above;
            ady_reg      <= (left_reg >= up_left_reg) ? left_reg - up_left_reg
                                                      : up_left_reg - left_reg;
            s2_coord_reg <= s1_coord_reg;
        end
        if (rdy3 && s2_v_reg)
        begin
            sqx_reg      <= adx_reg * adx_reg;
            sqy_reg      <= ady_reg * ady_reg;
            s3_coord_reg <= s2_coord_reg;
        end
        if (rdy4 && s3_v_reg)
        begin
            sum_reg      <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            s4_coord_reg <= s3_coord_reg;
        end
        if (rdyo && sq_valid)
        begin
            grad_reg      <= scaled[PIX_W-1:0];
            out_coord_reg <= sq_tag;
        end
    end

    gmf_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_v_reg),
        .in_stall  (sq_in_stall),
        .in_value  (sum_reg),
        .in_tag    (s4_coord_reg),
        .out_valid (sq_valid),
        .out_stall (!rdyo),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    assign scaled    = {{SCALE_W{1'b0}}, sq_root} * (ROOT_W+SCALE_W)'(GRAD_SCALE);

    assign out_valid = out_v_reg;
    assign gradient  = grad_reg;
    assign out_x     = out_coord_reg.x;
    assign out_y     = out_coord_reg.y;

    `GMF_ASSERT_IMP(a_pos_in_range, clk, rst_n, 1'b1, (x_reg <= lim_reg) && (y_reg <= lim_reg))
    `GMF_ASSERT_NEXT(a_interior_hits, clk, rst_n, accept && interior, s1_v_reg && s1_res_reg)
    `GMF_ASSERT_IMP(a_scale_mult4, clk, rst_n, out_valid, gradient[1:0] == 2'b00)
    `GMF_ASSERT_IMP(a_out_coord, clk, rst_n, out_valid, (out_x < lim_reg) && (out_y < lim_reg))

endmodule
